// ===== rtl/core/lbps_pkg.sv =====
package lbps_pkg;

   // Result status codes.
   typedef enum logic [1:0] {
      StAccepted = 2'd0,
      StDropped  = 2'd1,
      StSent     = 2'd2,
      StEmpty    = 2'd3
   } rsp_status_type;

   // Controller states.
   typedef enum logic [1:0] {
      StateIdle,
      StateFetch,
      StateCheck
   } ctrl_state_type;

   // Input kinds.
   localparam logic KindArrival = 1'b0;
   localparam logic KindTick    = 1'b1;

   // Most packets that one tick may release.
   localparam int MaxResults = 32;
   localparam int CntWidth   = 6;

   localparam logic [7:0] BucketReset = 8'd10;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic arrive;      // store or drop the incoming packet and report it
      logic tick_load;   // load credit, clear pop count and pending result
      logic pop;         // take the head packet into the pending result
      logic emit_pend;   // send the pending result
      logic emit_last;   // mark the result sent in this cycle as last
      logic emit_empty;  // send the empty-tick result
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic fits;        // head packet exists, fits credit, pops < limit
      logic pend_valid;  // a popped packet waits to be reported
   } dp_stat_type;

endpackage

// ===== rtl/core/leaky_bucket_packet_shaper_top.sv =====
// Byte-counting leaky bucket shaper with a circular packet queue. An item is
// transferred in at a rising edge where start is high and busy is low; every
// result is shown for exactly one cycle with rsp_valid high and cannot be held
// off, so the receiver must take each transfer as it comes. An arrival keeps
// busy low and its single result appears in the next cycle, so arrivals may be
// issued back to back. A tick raises busy while it releases its packets (at
// most 32), alternating check and fetch states: each check compares the head
// entry, read from the packet memory through a registered read port, against
// the remaining credit, and each fetch lets the next head be read. Each sent
// packet is reported one check later, once it is known whether it is the last
// of the tick. A tick that releases nothing gives one empty result. The bucket
// size may only be written while busy is low and no result is outstanding.
module leaky_bucket_packet_shaper_top #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,

   // Request channel.
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [7:0]  req_pkt_size,
   input  logic [15:0] req_pkt_id,

   // Result channel.
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_out_id,
   output logic [7:0]  rsp_out_size,
   output logic [5:0]  rsp_waiting,
   output logic        rsp_last,

   // Bucket size register.
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   lbps_pkg::dp_cmd_type  cmd;
   lbps_pkg::dp_stat_type stat;

   // The controller sequences arrivals and the pop loop of a tick.
   lbps_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   // The datapath holds the queue, the credit counter and the result register.
   lbps_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_pkt_size (req_pkt_size),
      .req_pkt_id   (req_pkt_id),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_out_id   (rsp_out_id),
      .rsp_out_size (rsp_out_size),
      .rsp_waiting  (rsp_waiting),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== rtl/core/lbps_ctrl.sv =====
module lbps_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_kind,
   input  lbps_pkg::dp_stat_type stat,
   output lbps_pkg::dp_cmd_type  cmd,
   output logic                  busy
);

   lbps_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lbps_pkg::StateIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         lbps_pkg::StateIdle: begin
            busy = 1'b0;
            if (start) begin
               if (req_kind == lbps_pkg::KindArrival) begin
                  cmd.arrive = 1'b1;
               end else begin
                  cmd.tick_load = 1'b1;
                  state_in      = lbps_pkg::StateCheck;
               end
            end
         end
         lbps_pkg::StateFetch: begin
            state_in = lbps_pkg::StateCheck;
         end
         lbps_pkg::StateCheck: begin
            // A previous pop is reported now; it is last only if nothing follows.
            cmd.emit_pend = stat.pend_valid;
            cmd.emit_last = !stat.fits;
            if (stat.fits) begin
               cmd.pop  = 1'b1;
               state_in = lbps_pkg::StateFetch;
            end else begin
               cmd.emit_empty = !stat.pend_valid;
               state_in       = lbps_pkg::StateIdle;
            end
         end
         default: begin
            state_in = lbps_pkg::StateIdle;
         end
      endcase
   end

endmodule

// ===== rtl/core/lbps_dp.sv =====
module lbps_dp #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lbps_pkg::dp_cmd_type  cmd,
   output lbps_pkg::dp_stat_type stat,
   input  logic [7:0]            req_pkt_size,
   input  logic [15:0]           req_pkt_id,
   input  logic                  csr_we,
   input  logic [7:0]            csr_wdata,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [15:0]           rsp_out_id,
   output logic [7:0]            rsp_out_size,
   output logic [5:0]            rsp_waiting,
   output logic                  rsp_last
);

   localparam int PtrWidth  = $clog2(QUEUE_DEPTH);
   localparam int FillWidth = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrWidth-1:0]  PtrLast = PtrWidth'(QUEUE_DEPTH - 1);
   localparam logic [FillWidth-1:0] FillMax = FillWidth'(QUEUE_DEPTH);

   // Each entry holds {size, id}.
   logic [23:0] mem [QUEUE_DEPTH];
   logic [23:0] rd_data_ff;

   logic [PtrWidth-1:0]  head_ff, tail_ff;
   logic [FillWidth-1:0] fill_ff;
   logic [7:0]           bucket_ff;
   logic [7:0]           credit_ff;
   logic [lbps_pkg::CntWidth-1:0] pops_ff;

   logic        pend_valid_ff;
   logic [15:0] pend_id_ff;
   logic [7:0]  pend_size_ff;
   logic [5:0]  pend_wait_ff;

   logic                     rsp_valid_ff;
   lbps_pkg::rsp_status_type rsp_status_ff;
   logic [15:0]              rsp_id_ff;
   logic [7:0]               rsp_size_ff;
   logic [5:0]               rsp_wait_ff;
   logic                     rsp_last_ff;

   logic       not_full;
   logic [7:0] head_size;

   assign not_full  = (fill_ff != FillMax);
   assign head_size = rd_data_ff[23:16];

   assign stat.fits = (fill_ff != '0)
                      && (pops_ff < lbps_pkg::CntWidth'(lbps_pkg::MaxResults))
                      && (head_size <= credit_ff);
   assign stat.pend_valid = pend_valid_ff;

   // Packet memory: written at the tail, read at the head every cycle.
   always_ff @(posedge clock) begin
      if (cmd.arrive && not_full) begin
         mem[tail_ff] <= {req_pkt_size, req_pkt_id};
      end
      rd_data_ff <= mem[head_ff];
   end

   // Queue pointers, fill count and bucket size.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         fill_ff   <= '0;
         bucket_ff <= lbps_pkg::BucketReset;
      end else begin
         if (csr_we) begin
            bucket_ff <= csr_wdata;
         end
         if (cmd.arrive && not_full) begin
            tail_ff <= (tail_ff == PtrLast) ? '0 : tail_ff + 1'b1;
            fill_ff <= fill_ff + 1'b1;
         end
         if (cmd.pop) begin
            head_ff <= (head_ff == PtrLast) ? '0 : head_ff + 1'b1;
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

   // Tick working state: credit, pop count and the result held back
   // until it is known whether another packet follows it.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.tick_load) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.pop) begin
         pend_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tick_load) begin
         credit_ff <= bucket_ff;
         pops_ff   <= '0;
      end else if (cmd.pop) begin
         credit_ff    <= credit_ff - head_size;
         pops_ff      <= pops_ff + 1'b1;
         pend_id_ff   <= rd_data_ff[15:0];
         pend_size_ff <= head_size;
         pend_wait_ff <= 6'(fill_ff - 1'b1);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.arrive || cmd.emit_pend || cmd.emit_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.arrive) begin
         rsp_status_ff <= not_full ? lbps_pkg::StAccepted : lbps_pkg::StDropped;
         rsp_id_ff     <= req_pkt_id;
         rsp_size_ff   <= req_pkt_size;
         rsp_wait_ff   <= not_full ? 6'(fill_ff + 1'b1) : 6'(fill_ff);
         rsp_last_ff   <= 1'b1;
      end else if (cmd.emit_pend) begin
         rsp_status_ff <= lbps_pkg::StSent;
         rsp_id_ff     <= pend_id_ff;
         rsp_size_ff   <= pend_size_ff;
         rsp_wait_ff   <= pend_wait_ff;
         rsp_last_ff   <= cmd.emit_last;
      end else if (cmd.emit_empty) begin
         rsp_status_ff <= lbps_pkg::StEmpty;
         rsp_id_ff     <= '0;
         rsp_size_ff   <= '0;
         rsp_wait_ff   <= 6'(fill_ff);
         rsp_last_ff   <= 1'b1;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_out_id   = rsp_id_ff;
   assign rsp_out_size = rsp_size_ff;
   assign rsp_waiting  = rsp_wait_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// ===== tb/sv/leaky_bucket_packet_shaper_top_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the leaky bucket shaper. Items go in over the
// start/busy handshake and every result transfer is compared, field by
// field, with what a behavioural copy of the shaper inside this bench
// predicts. The receiving side has no way to push back, so the monitor
// simply takes each result transfer in the cycle that it appears.
module leaky_bucket_packet_shaper_top_tb;

   localparam int QueueDepth    = 32;
   localparam int WatchdogLimit = 600;
   localparam int PrintLimit    = 40;
   localparam int PhaseItems    = 55;

   // One result transfer as the shaper reports it.
   typedef struct packed {
      lbps_pkg::rsp_status_type status;
      logic [15:0]              id;
      logic [7:0]               size;
      logic [5:0]               waiting;
      logic                     last;
   } shaper_result_type;

   // Rows of the directed table. A bucket row carries the new bucket size
   // in its size column. Where typed is set the row gives the expected
   // result outright and it replaces the predicted one.
   typedef enum logic [1:0] {
      RowArrive,
      RowTick,
      RowBucket
   } row_op_type;

   typedef struct packed {
      row_op_type               op;
      logic [7:0]               size;
      logic [15:0]              id;
      logic                     typed;
      lbps_pkg::rsp_status_type exp_status;
      logic [15:0]              exp_id;
      logic [7:0]               exp_size;
      logic [5:0]               exp_waiting;
   } stim_row_type;

   // The directed part starts from the reset bucket size of 10. It covers an
   // empty tick, a head packet too large for the bucket that stays blocked,
   // zero-size packets that cost no credit, tick fields that are ignored, the
   // field extremes and bucket settings of 1, 10, 128 and 255.
   stim_row_type directed_rows [22] = '{
      '{RowTick,   8'hFF, 16'hFFFF, 1'b1, lbps_pkg::StEmpty,    16'h0000, 8'h00, 6'd0},
      '{RowArrive, 8'hFF, 16'hFFFF, 1'b1, lbps_pkg::StAccepted, 16'hFFFF, 8'hFF, 6'd1},
      '{RowTick,   8'h00, 16'h0000, 1'b1, lbps_pkg::StEmpty,    16'h0000, 8'h00, 6'd1},
      '{RowTick,   8'hA5, 16'h5A5A, 1'b1, lbps_pkg::StEmpty,    16'h0000, 8'h00, 6'd1},
      '{RowArrive, 8'h00, 16'h0000, 1'b1, lbps_pkg::StAccepted, 16'h0000, 8'h00, 6'd2},
      '{RowArrive, 8'h01, 16'h5555, 1'b1, lbps_pkg::StAccepted, 16'h5555, 8'h01, 6'd3},
      '{RowBucket, 8'hFF, 16'h0000, 1'b0, lbps_pkg::StEmpty,    16'h0000, 8'h00, 6'd0},
      '{RowTick,   8'h00, 16'h0000, 1'b0, lbps_pkg::StEmpty,    16'h0000, 8'h00, 6'd0},
      '{RowTick,   8'h3C, 16'hC3C3, 1'b0, lbps_pkg::StEmpty,    16'h0000, 8'h00, 6'd0},
      '{RowBucket, 8'h01, 16'h0000, 1'b0, lbps_pkg::StEmpty,    16'h0000, 8'h00, 6'd0},
      '{RowArrive, 8'h01, 16'hAAAA, 1'b1, lbps_pkg::StAccepted, 16'hAAAA, 8'h01, 6'd1},
      '{RowArrive, 8'h02, 16'h1234, 1'b1, lbps_pkg::StAccepted, 16'h1234, 8'h02, 6'd2},
      '{RowArrive, 8'h00, 16'h8001, 1'b1, lbps_pkg::StAccepted, 16'h8001, 8'h00, 6'd3},
      '{RowTick,   8'h00, 16'h0000, 1'b0, lbps_pkg::StEmpty,    16'h0000, 8'h00, 6'd0},
      '{RowTick,   8'h00, 16'h0000, 1'b1, lbps_pkg::StEmpty,    16'h0000, 8'h00, 6'd2},
      '{RowBucket, 8'h80, 16'h0000, 1'b0, lbps_pkg::StEmpty,    16'h0000, 8'h00, 6'd0},
      '{RowTick,   8'h00, 16'h0000, 1'b0, lbps_pkg::StEmpty,    16'h0000, 8'h00, 6'd0},
      '{RowArrive, 8'h80, 16'h7FFF, 1'b1, lbps_pkg::StAccepted, 16'h7FFF, 8'h80, 6'd1},
      '{RowArrive, 8'h7F, 16'hC3C3, 1'b1, lbps_pkg::StAccepted, 16'hC3C3, 8'h7F, 6'd2},
      '{RowTick,   8'h00, 16'h0000, 1'b0, lbps_pkg::StEmpty,    16'h0000, 8'h00, 6'd0},
      '{RowBucket, 8'h0A, 16'h0000, 1'b0, lbps_pkg::StEmpty,    16'h0000, 8'h00, 6'd0},
      '{RowTick,   8'hFF, 16'hFFFF, 1'b1, lbps_pkg::StEmpty,    16'h0000, 8'h00, 6'd1}
   };

   // Bucket sizes of the random phases; zero stands for a random setting.
   logic [7:0] phase_buckets [6] = '{8'd255, 8'd1, 8'd0, 8'd40, 8'd0, 8'd255};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_kind = lbps_pkg::KindArrival;
   logic [7:0]  req_pkt_size = 8'd0;
   logic [15:0] req_pkt_id = 16'd0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_out_id;
   logic [7:0]  rsp_out_size;
   logic [5:0]  rsp_waiting;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic [7:0]  csr_wdata = 8'd0;

   // Behavioural copy of the shaper: the packet queue, its pointers and the
   // bucket size as they stand after every accepted item.
   logic [7:0]  shadow_size [QueueDepth];
   logic [15:0] shadow_id [QueueDepth];
   int          shadow_head = 0;
   int          shadow_tail = 0;
   int          shadow_fill = 0;
   logic [7:0]  shadow_bucket = lbps_pkg::BucketReset;

   // Results that the shaper still owes, oldest first.
   shaper_result_type pending_reports [$];
   shaper_result_type oldest_report;

   int mismatches = 0;
   int results_seen = 0;
   int arrivals_sent = 0;
   int ticks_sent = 0;
   int packets_released = 0;
   int packets_dropped = 0;
   int empty_ticks = 0;
   int full_pop_ticks = 0;
   int bucket_writes = 0;
   int burst_left = 0;
   int quiet_cycles = 0;

   leaky_bucket_packet_shaper_top #(
      .QUEUE_DEPTH(QueueDepth)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_kind    (req_kind),
      .req_pkt_size(req_pkt_size),
      .req_pkt_id  (req_pkt_id),
      .rsp_valid   (rsp_valid),
      .rsp_status  (rsp_status),
      .rsp_out_id  (rsp_out_id),
      .rsp_out_size(rsp_out_size),
      .rsp_waiting (rsp_waiting),
      .rsp_last    (rsp_last),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   always #2 clock = ~clock;

   // Prints one line per mismatch, up to a limit, and counts every one.
   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < PrintLimit) begin
         $display("%0t ns: mismatch on %s, got 0x%0h, expected 0x%0h", $time, what, got,
                  want);
      end
      mismatches++;
   endtask

   // Works out the results of one accepted item and queues them. An arrival
   // is stored when there is room and dropped otherwise. A tick loads the
   // credit with the bucket size and releases head packets for as long as
   // they fit, at most MaxResults of them; a tick that releases nothing
   // leaves a single empty report with id and size cleared.
   task automatic shape_packet_item(input logic kind, input logic [7:0] size,
                                    input logic [15:0] id);
      logic [7:0] credit;
      int released;

      if (kind == lbps_pkg::KindArrival) begin
         if (shadow_fill < QueueDepth) begin
            shadow_size[shadow_tail] = size;
            shadow_id[shadow_tail] = id;
            shadow_tail = (shadow_tail + 1) % QueueDepth;
            shadow_fill++;
            pending_reports.push_back('{lbps_pkg::StAccepted, id, size, 6'(shadow_fill),
                                        1'b1});
         end else begin
            packets_dropped++;
            pending_reports.push_back('{lbps_pkg::StDropped, id, size, 6'(shadow_fill),
                                        1'b1});
         end
      end else begin
         credit = shadow_bucket;
         released = 0;
         while (shadow_fill > 0 && released < lbps_pkg::MaxResults &&
                credit >= shadow_size[shadow_head]) begin
            credit = credit - shadow_size[shadow_head];
            shadow_fill--;
            pending_reports.push_back('{lbps_pkg::StSent, shadow_id[shadow_head],
                                        shadow_size[shadow_head], 6'(shadow_fill), 1'b0});
            shadow_head = (shadow_head + 1) % QueueDepth;
            released++;
         end
         if (released == 0) begin
            empty_ticks++;
            pending_reports.push_back('{lbps_pkg::StEmpty, 16'h0000, 8'h00, 6'(shadow_fill),
                                        1'b1});
         end else begin
            pending_reports[pending_reports.size() - 1].last = 1'b1;
         end
         if (released == lbps_pkg::MaxResults) begin
            full_pop_ticks++;
         end
         packets_released += released;
      end
   endtask

   // Offers one item and holds it until the shaper takes the transfer. The
   // sender works in bursts: when a burst is used up it may drop start for
   // a random gap before the next one begins, so the gaps land at random
   // points of whatever the shaper is doing.
   task automatic send_item(input logic kind, input logic [7:0] size, input logic [15:0] id);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      start <= 1'b1;
      req_kind <= kind;
      req_pkt_size <= size;
      req_pkt_id <= id;
      // Busy is read before the edge updates it, so the transfer happens at
      // the first edge that sees busy low.
      do begin
         @(posedge clock);
      end while (busy);
      if (kind == lbps_pkg::KindArrival) begin
         arrivals_sent++;
      end else begin
         ticks_sent++;
      end
      shape_packet_item(kind, size, id);
   endtask

   // Changes the bucket size once the shaper has gone quiet: start is
   // dropped, every owed result must have come back and busy must be low.
   // Every item gives at least one result, so no extra settling is needed.
   task automatic write_bucket(input logic [7:0] value);
      start <= 1'b0;
      while (pending_reports.size() != 0 || busy) begin
         @(posedge clock);
      end
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_bucket = value;
      bucket_writes++;
   endtask

   // Result monitor. Each result transfer is matched against the oldest
   // owed result; a transfer with nothing owed counts as a failure.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         results_seen++;
         if (pending_reports.size() == 0) begin
            report_mismatch("unexpected result, status", rsp_status, 0);
         end else begin
            oldest_report = pending_reports.pop_front();
            if (rsp_status !== oldest_report.status)
               report_mismatch("status", rsp_status, oldest_report.status);
            if (rsp_out_id !== oldest_report.id)
               report_mismatch("out_id", rsp_out_id, oldest_report.id);
            if (rsp_out_size !== oldest_report.size)
               report_mismatch("out_size", rsp_out_size, oldest_report.size);
            if (rsp_waiting !== oldest_report.waiting)
               report_mismatch("waiting", rsp_waiting, oldest_report.waiting);
            if (rsp_last !== oldest_report.last)
               report_mismatch("last", rsp_last, oldest_report.last);
         end
      end
   end

   // Watchdog. It counts cycles in which neither an item nor a result is
   // transferred. The longest quiet stretch in a correct run is a sender
   // gap or a bucket write, far below the limit, since a tick reports each
   // released packet at the check that follows its pop.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
         $display("Watchdog: no transfer for %0d cycles, %0d results still owed.",
                  quiet_cycles, pending_reports.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      logic [7:0]   setting;
      logic [7:0]   size;
      int           size_cap;
      int           phase_items;
      int           train;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table. Typed rows overwrite the single predicted result
      // with the value written in the table.
      for (int r = 0; r < 22; r++) begin
         row = directed_rows[r];
         case (row.op)
            RowBucket: begin
               write_bucket(row.size);
            end
            default: begin
               send_item((row.op == RowTick) ? lbps_pkg::KindTick : lbps_pkg::KindArrival,
                         row.size, row.id);
               if (row.typed) begin
                  pending_reports[pending_reports.size() - 1] =
                     '{row.exp_status, row.exp_id, row.exp_size, row.exp_waiting, 1'b1};
               end
            end
         endcase
      end

      // Random phases, each with its own bucket size. Most traffic is trains
      // of arrivals followed by a few ticks, so the queue fills, overflows
      // and drains. In the first phase the bucket is at its largest and the
      // packets are tiny, so a full queue empties in a single tick and hits
      // the pop limit. Elsewhere an odd oversized packet can block the head
      // until a later phase raises the bucket far enough.
      for (int phase = 0; phase < 6; phase++) begin
         setting = phase_buckets[phase];
         if (setting == 8'd0) begin
            setting = 8'($urandom_range(1, 255));
         end
         write_bucket(setting);
         size_cap = (phase == 0) ? 7 : setting;
         phase_items = 0;
         while (phase_items < PhaseItems) begin
            train = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 40)
                                                : $urandom_range(0, 10);
            repeat (train) begin
               if (phase != 0 && $urandom_range(0, 7) == 0) begin
                  size = 8'($urandom_range(0, 255));
               end else begin
                  size = 8'($urandom_range(0, size_cap));
               end
               send_item(lbps_pkg::KindArrival, size, 16'($urandom));
               phase_items++;
            end
            repeat ($urandom_range(1, 3)) begin
               send_item(lbps_pkg::KindTick, 8'($urandom), 16'($urandom));
               phase_items++;
            end
         end
      end

      // Drain: wait for every owed result, then let the clock run on in case
      // something stray follows. The watchdog bounds this wait.
      start <= 1'b0;
      while (pending_reports.size() != 0 || busy) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      $display("Covered %0d arrivals and %0d ticks over %0d bucket settings; %0d results checked.",
               arrivals_sent, ticks_sent, bucket_writes, results_seen);
      $display("Released %0d packets, dropped %0d, %0d empty ticks, %0d ticks at the pop limit.",
               packets_released, packets_dropped, empty_ticks, full_pop_ticks);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches in total.", mismatches);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/lbps_pkg.sv
rtl/core/lbps_ctrl.sv
rtl/core/lbps_dp.sv
rtl/core/leaky_bucket_packet_shaper_top.sv
tb/sv/leaky_bucket_packet_shaper_top_tb.sv
